FILE: src/blm_pkg.sv
// blm_pkg: shared types and constants for the battery level monitor
// used by blm_divider and battery_level_monitor
`default_nettype none

package blm_pkg;

   localparam int unsigned REF_SCALE = 1224;
   localparam int unsigned SCALE_BITS = 11;
   localparam int unsigned VOLT_BITS = 16;
   localparam int unsigned SUM_BITS = 18;
   localparam int unsigned LEVEL_BITS = 2;
   localparam int unsigned CSR_ADDR_BITS = 4;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned RSP_DATA_BITS = 40;

   localparam logic [VOLT_BITS-1:0] VOLT_MAX = 16'hFFFF;

   localparam logic [LEVEL_BITS-1:0] LEVEL_DOWN = 2'd0;
   localparam logic [LEVEL_BITS-1:0] LEVEL_REMIND = 2'd1;
   localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = 2'd2;

   localparam logic [1:0] REG_DOWN = 2'd0;
   localparam logic [1:0] REG_REMIND = 2'd1;
   localparam logic [1:0] REG_WORK = 2'd2;
   localparam logic [1:0] REG_FULL = 2'd3;

   localparam logic [VOLT_BITS-1:0] DOWN_RESET = 16'd913;
   localparam logic [VOLT_BITS-1:0] REMIND_RESET = 16'd1035;
   localparam logic [VOLT_BITS-1:0] WORK_RESET = 16'd1159;
   localparam logic [VOLT_BITS-1:0] FULL_RESET = 16'd1240;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

FILE: src/blm_divider.sv
// blm_divider: restoring divider, one quotient bit per cycle
// depends on blm_pkg for the status struct
`default_nettype none

module blm_divider #(
   parameter int unsigned NUM_W = 23,
   parameter int unsigned DEN_W = 12
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [NUM_W-1:0]           numerator,
   input  wire logic [DEN_W-1:0]           denominator,
   output blm_pkg::div_status_type         status,
   output logic [NUM_W-1:0]                quotient
);
   import blm_pkg::*;

   localparam int unsigned CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0]   rem_shift;
   logic [DEN_W+1:0] diff;
   logic             ge;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUM_W-1]};
      diff = {1'b0, rem_shift} - {2'b00, den_ff};
      ge = ~diff[DEN_W+1];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = numerator;
         den_in = denominator;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: src/battery_level_monitor.sv
// battery_level_monitor: top level, request/response streams and register port
// depends on blm_pkg and blm_divider
//
// usage:
//   a request carries a battery channel reading and a reference reading in
//   req_tdata, and the update flag in req_tuser. each request gives exactly
//   one response: the scaled voltage 1224*channel/reference (clamped, and
//   all ones for a zero reference), the power level and the recorded value.
//   the shared divider retires one quotient bit per cycle over 1224*channel,
//   then the finish step loads the output register; one request is in work
//   at a time, so a new request is not taken until the previous one has
//   reached the output register.
//   a finished response waits in the output register when the receiver
//   stalls; a new request is taken meanwhile and parks after its division
//   until the register frees.
//   reset clears averaging state, sets level to full and restores the
//   threshold registers; the user must write thresholds through the register
//   port only while the block is idle, as the block itself does not enforce it.
`default_nettype none

module battery_level_monitor #(
   parameter int unsigned SAMPLE_BITS = 12
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // req_tdata: channel_sample, reference_sample, zero fill
   input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   // req_tuser: update_enable
   input  wire logic                                   req_tuser,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // rsp_tdata: voltage, power_level, battery_value, zero fill
   output logic [blm_pkg::RSP_DATA_BITS-1:0]           rsp_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [blm_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  wire logic [blm_pkg::CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [blm_pkg::CSR_DATA_BITS-1:0]           csr_prdata,
   output logic                                        csr_pready
);
   import blm_pkg::*;

   localparam int unsigned NUM_W = SAMPLE_BITS + SCALE_BITS;

   // registers
   logic [VOLT_BITS-1:0]  down_thr_ff, remind_thr_ff, work_thr_ff, full_thr_ff;
   logic                  csr_write;
   logic [1:0]            csr_index;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         down_thr_ff <= DOWN_RESET;
         remind_thr_ff <= REMIND_RESET;
         work_thr_ff <= WORK_RESET;
         full_thr_ff <= FULL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_DOWN: down_thr_ff <= csr_pwdata[VOLT_BITS-1:0];
            REG_REMIND: remind_thr_ff <= csr_pwdata[VOLT_BITS-1:0];
            REG_WORK: work_thr_ff <= csr_pwdata[VOLT_BITS-1:0];
            REG_FULL: full_thr_ff <= csr_pwdata[VOLT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_DOWN: csr_prdata = {16'h0000, down_thr_ff};
         REG_REMIND: csr_prdata = {16'h0000, remind_thr_ff};
         REG_WORK: csr_prdata = {16'h0000, work_thr_ff};
         REG_FULL: csr_prdata = {16'h0000, full_thr_ff};
         default: csr_prdata = '0;
      endcase
   end

   // sequencer
   state_type            state_ff, state_in;
   logic                 req_accept;
   logic                 div_start;
   logic                 rsp_load;
   div_status_type       div_status;
   logic [NUM_W-1:0]     div_quotient;
   logic [NUM_W-1:0]     numerator;
   logic [SAMPLE_BITS-1:0] channel, reference;

   assign channel = req_tdata[SAMPLE_BITS-1:0];
   assign reference = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign numerator = NUM_W'(REF_SCALE) * NUM_W'(channel);
   assign req_accept = req_tvalid & req_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_accept) state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_status.done) state_in = ST_FINISH;
         ST_FINISH: if (!rsp_tvalid || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      div_start = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            div_start = req_tvalid;
         end
         ST_DIVIDE: ;
         ST_FINISH: rsp_load = !rsp_tvalid || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   blm_divider #(
      .NUM_W(NUM_W),
      .DEN_W(SAMPLE_BITS)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numerator(numerator),
      .denominator(reference),
      .status(div_status),
      .quotient(div_quotient)
   );

   // request side fields held over the division
   logic upd_ff, ref_zero_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         upd_ff <= req_tuser;
         ref_zero_ff <= (reference == '0);
      end
   end

   // averaging and level state
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [1:0]            count_ff, count_in;
   logic                  first_ff, first_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [VOLT_BITS-1:0]  record_ff, record_in;
   logic [VOLT_BITS-1:0]  volt;
   logic [SUM_BITS-1:0]   sum_add;
   logic [VOLT_BITS-1:0]  avg;

   always_comb begin
      if (ref_zero_ff || (div_quotient[NUM_W-1:VOLT_BITS] != '0)) begin
         volt = VOLT_MAX;
      end else begin
         volt = div_quotient[VOLT_BITS-1:0];
      end
   end

   always_comb begin
      sum_add = sum_ff + SUM_BITS'(volt);
      avg = sum_add[SUM_BITS-1:2];
      sum_in = sum_ff;
      count_in = count_ff;
      first_in = first_ff;
      level_in = level_ff;
      record_in = record_ff;
      if (upd_ff) begin
         sum_in = sum_add;
         count_in = count_ff + 1'b1;
         if (count_in == 2'd0) begin
            sum_in = '0;
            if (avg < down_thr_ff) begin
               level_in = LEVEL_DOWN;
            end else if (avg < remind_thr_ff) begin
               level_in = LEVEL_REMIND;
            end
            record_in = avg;
         end
         if (!first_ff) begin
            first_in = 1'b1;
            record_in = volt;
            if (volt < remind_thr_ff) level_in = LEVEL_REMIND;
         end
         if (volt > full_thr_ff) begin
            if (level_in != LEVEL_FULL) record_in = volt;
            level_in = LEVEL_FULL;
         end else if (volt > work_thr_ff) begin
            if (level_in == LEVEL_DOWN) level_in = LEVEL_REMIND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         count_ff <= '0;
         first_ff <= 1'b0;
         level_ff <= LEVEL_FULL;
         record_ff <= '0;
      end else if (rsp_load) begin
         sum_ff <= sum_in;
         count_ff <= count_in;
         first_ff <= first_in;
         level_ff <= level_in;
         record_ff <= record_in;
      end
   end

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {6'b000000, record_in, level_in, volt};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request taken while a division is running");

   a_response_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish step");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide step");

   a_level_code: assert property (@(posedge clock) disable iff (reset)
      (level_ff == LEVEL_DOWN) || (level_ff == LEVEL_REMIND) || (level_ff == LEVEL_FULL))
      else $error("power level holds an unused code");
`endif

endmodule

`default_nettype wire

FILE: tb/battery_level_monitor_test.sv
`timescale 1ns / 1ps
// battery_level_monitor_test: self-checking testbench for the battery level monitor,
// with directed readings, random readings and threshold sweeps over the register port
// depends on blm_pkg and battery_level_monitor

module battery_level_monitor_test;
   import blm_pkg::*;

   typedef struct packed {
      logic [15:0] battery;
      logic [1:0]  level;
      logic [15:0] voltage;
   } monitor_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic        csr_pready;

   logic req_gaps_on = 1'b1;
   logic rsp_stalls_on = 1'b1;
   int unsigned mismatch_count = 0;
   monitor_report_type pending_reports[$];

   // predictor state
   logic [15:0] thresholds [4] = '{DOWN_RESET, REMIND_RESET, WORK_RESET, FULL_RESET};
   logic [17:0] volt_sum = '0;
   logic [1:0]  avg_count = '0;
   logic        primed = 1'b0;
   logic [1:0]  cur_level = LEVEL_FULL;
   logic [15:0] held_value = '0;

   battery_level_monitor u_dut (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= !rsp_stalls_on || ($urandom_range(99) >= 34);
   end

   function automatic monitor_report_type predict_report(input logic [11:0] ch_smp,
                                                         input logic [11:0] rf_smp,
                                                         input logic upd);
      int unsigned volts;
      logic [15:0] avg;
      monitor_report_type r;
      if (rf_smp == 0) begin
         volts = 32'(VOLT_MAX);
      end else begin
         volts = (REF_SCALE * ch_smp) / rf_smp;
         if (volts > VOLT_MAX) volts = 32'(VOLT_MAX);
      end
      if (upd) begin
         volt_sum = volt_sum + volts[15:0];
         avg_count = avg_count + 2'd1;
         if (avg_count == 0) begin
            avg = volt_sum[17:2];
            volt_sum = '0;
            if (avg < thresholds[REG_DOWN]) cur_level = LEVEL_DOWN;
            else if (avg < thresholds[REG_REMIND]) cur_level = LEVEL_REMIND;
            held_value = avg;
         end
         if (!primed) begin
            primed = 1'b1;
            held_value = volts[15:0];
            if (volts < thresholds[REG_REMIND]) cur_level = LEVEL_REMIND;
         end
         if (volts > thresholds[REG_FULL]) begin
            if (cur_level <= LEVEL_REMIND) held_value = volts[15:0];
            cur_level = LEVEL_FULL;
         end else if (volts > thresholds[REG_WORK]) begin
            if (cur_level == LEVEL_DOWN) cur_level = LEVEL_REMIND;
         end
      end
      r.voltage = volts[15:0];
      r.level = cur_level;
      r.battery = held_value;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("%0t %s: got %0d want %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      monitor_report_type got;
      monitor_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[33:0];
         if (pending_reports.size() == 0) begin
            report_mismatch("response with no request pending", got.voltage, 0);
         end else begin
            want = pending_reports.pop_front();
            if (got.voltage !== want.voltage)
               report_mismatch("voltage", got.voltage, want.voltage);
            if (got.level !== want.level)
               report_mismatch("power level", got.level, want.level);
            if (got.battery !== want.battery)
               report_mismatch("battery value", got.battery, want.battery);
         end
      end
   end

   task automatic send_reading(input logic [11:0] ch_smp, input logic [11:0] rf_smp,
                               input logic upd);
      while (req_gaps_on && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {rf_smp, ch_smp};
      req_tuser <= upd;
      do @(posedge clock); while (!req_tready);
      pending_reports.push_back(predict_report(ch_smp, rf_smp, upd));
   endtask

   task automatic drain_pending();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [1:0] idx, input logic [15:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      thresholds[idx] = value;
   endtask

   task automatic load_thresholds(input logic [15:0] down_v, input logic [15:0] remind_v,
                                  input logic [15:0] work_v, input logic [15:0] full_v);
      drain_pending();
      write_threshold(REG_DOWN, down_v);
      write_threshold(REG_REMIND, remind_v);
      write_threshold(REG_WORK, work_v);
      write_threshold(REG_FULL, full_v);
      csr_psel <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_random_readings(input int count);
      logic [11:0] ch_smp;
      logic [11:0] rf_smp;
      logic upd;
      int unsigned pick;
      longint target;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         upd = ($urandom_range(99) < 80);
         if (pick < 4) begin
            ch_smp = 12'($urandom);
            rf_smp = '0;
         end else if (pick < 30) begin
            ch_smp = 12'($urandom);
            rf_smp = 12'($urandom);
         end else begin
            // aim near one of the thresholds so the level keeps moving
            target = longint'(thresholds[2'($urandom_range(3))]) + $urandom_range(64) - 32;
            if (target < 0) target = 0;
            if (target > VOLT_MAX) target = VOLT_MAX;
            rf_smp = 12'($urandom_range(1024, 4095));
            target = (target * rf_smp) / REF_SCALE;
            ch_smp = (target > 4095) ? 12'hFFF : target[11:0];
         end
         send_reading(ch_smp, rf_smp, upd);
      end
   endtask

   task automatic test_directed_readings();
      // compute only: zero reference, clamp, extremes
      send_reading(12'd0, 12'd0, 1'b0);
      send_reading(12'hFFF, 12'd0, 1'b0);
      send_reading(12'hFFF, 12'd1, 1'b0);
      send_reading(12'd0, 12'hFFF, 1'b0);
      send_reading(12'hFFF, 12'hFFF, 1'b0);
      send_reading(12'd1, 12'hFFF, 1'b0);
      send_reading(12'hAAA, 12'h555, 1'b0);
      send_reading(12'h555, 12'hAAA, 1'b0);
      // first sample, then an average that drops to down
      send_reading(12'd1000, 12'd1224, 1'b1);
      send_reading(12'd800, 12'd1224, 1'b1);
      send_reading(12'd800, 12'd1224, 1'b1);
      send_reading(12'd800, 12'd1224, 1'b1);
      send_reading(12'd900, 12'd1224, 1'b0);
      // hysteresis: down to remind, then full
      send_reading(12'd1200, 12'd1224, 1'b1);
      send_reading(12'd1300, 12'd1224, 1'b1);
      send_reading(12'd1000, 12'd1224, 1'b1);
      send_reading(12'd1000, 12'd1224, 1'b1);
      send_reading(12'hFFF, 12'd1, 1'b1);
      send_reading(12'd0, 12'd0, 1'b1);
      send_reading(12'd0, 12'hFFF, 1'b1);
      send_reading(12'd0, 12'hFFF, 1'b1);
      send_reading(12'd0, 12'hFFF, 1'b1);
   endtask

   task automatic test_reset_thresholds();
      send_random_readings(200);
   endtask

   task automatic test_zero_thresholds();
      load_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
      send_random_readings(200);
   endtask

   task automatic test_max_thresholds();
      load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_random_readings(200);
   endtask

   task automatic test_ordered_thresholds();
      logic [15:0] d;
      logic [15:0] r;
      logic [15:0] w;
      logic [15:0] f;
      for (int k = 0; k < 3; k++) begin
         d = 16'($urandom_range(500, 1100));
         r = d + 16'($urandom_range(200));
         w = r + 16'($urandom_range(200));
         f = w + 16'($urandom_range(200));
         load_thresholds(d, r, w, f);
         send_random_readings(150);
      end
   endtask

   task automatic test_unordered_thresholds();
      load_thresholds(16'($urandom_range(400, 1600)), 16'($urandom_range(400, 1600)),
                      16'($urandom_range(400, 1600)), 16'($urandom_range(400, 1600)));
      send_random_readings(150);
   endtask

   task automatic test_back_to_back();
      load_thresholds(DOWN_RESET, REMIND_RESET, WORK_RESET, FULL_RESET);
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      send_random_readings(250);
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_readings();
      test_reset_thresholds();
      test_zero_thresholds();
      test_max_thresholds();
      test_ordered_thresholds();
      test_unordered_thresholds();
      test_back_to_back();
      drain_pending();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("battery_level_monitor: match");
      end else begin
         $display("battery_level_monitor: mismatch");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("battery_level_monitor: mismatch");
      $finish;
   end

endmodule

FILE: files.f
src/blm_pkg.sv
src/blm_divider.sv
src/battery_level_monitor.sv
tb/battery_level_monitor_test.sv
